[rtl/pid_separation_antiwindup_unit_defines.svh]
// Assertion macros shared by the PID separation anti-windup unit.
`ifndef PID_SEPARATION_ANTIWINDUP_UNIT_DEFINES_SVH
`define PID_SEPARATION_ANTIWINDUP_UNIT_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define PIDSA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define PIDSA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pidsa_pkg.sv]
// Shared types, widths and constants of the PID separation anti-windup unit.
`default_nettype none

package pidsa_pkg;

  // Field widths of the Q16.16 data path.
  localparam int DATA_W  = 32;
  localparam int GAIN_W  = 31;
  localparam int INTEG_W = 40;
  localparam int FRAC_W  = 16;
  localparam int ALPHA_W = 16;
  localparam int ADDR_W  = 5;

  // Derivative filter coefficient, an unsigned Q0.16 fraction fixed at build time.
  localparam logic [ALPHA_W-1:0] FILTER_ALPHA = 16'd0;

  // Widths of the products and the partial sums.
  localparam int PROD_W    = GAIN_W + DATA_W;               // gain times a 32-bit value
  localparam int PTERM_W   = PROD_W - FRAC_W;               // after the shift by 16
  localparam int IHI_W     = INTEG_W - FRAC_W;              // upper part of the integral
  localparam int IHIPROD_W = GAIN_W + IHI_W;                // gain times upper part
  localparam int ILO_W     = GAIN_W;                        // shifted lower product
  localparam int ITERM_W   = IHIPROD_W + 1;                 // integral term
  localparam int DSUM_W    = PTERM_W + 1;                   // filtered derivative sum
  localparam int APROD_W   = ALPHA_W + DATA_W;              // alpha times prior derivative
  localparam int SUM_W     = ITERM_W + 1;                   // final output sum

  // Action codes of an input item.
  localparam logic ACT_REGULATE = 1'b0;
  localparam logic ACT_CLEAR    = 1'b1;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEG_GAIN     = 3'd1,
    REG_DERIV_GAIN_EFF = 3'd2,
    REG_SEP_THRESHOLD  = 3'd3,
    REG_WINDUP_HIGH    = 3'd4,
    REG_WINDUP_LOW     = 3'd5,
    REG_OUT_HIGH       = 3'd6,
    REG_OUT_LOW        = 3'd7
  } reg_idx_t;

  // Current configuration as seen by the data path.
  typedef struct packed {
    logic        [GAIN_W-1:0] prop_gain;
    logic        [GAIN_W-1:0] integ_gain;
    logic        [GAIN_W-1:0] deriv_gain_eff;
    logic        [GAIN_W-1:0] separation_threshold;
    logic signed [DATA_W-1:0] windup_high;
    logic signed [DATA_W-1:0] windup_low;
    logic signed [DATA_W-1:0] out_high;
    logic signed [DATA_W-1:0] out_low;
  } pidsa_cfg_t;

  // Load strobes of the pipeline registers, from the flow control.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld_out;
  } pidsa_adv_t;

endpackage

`default_nettype wire

[rtl/pidsa_if.sv]
// Valid/ready channel interfaces for the sample input and the result output.
`default_nettype none

interface pidsa_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [31:0]       setpoint;
  logic signed [31:0]       measured;

  modport source (output valid, output action, output setpoint, output measured,
                  input ready);
  modport sink   (input valid, input action, input setpoint, input measured,
                  output ready);
endinterface

interface pidsa_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       drive;
  logic                     integ_active;

  modport source (output valid, output drive, output integ_active, input ready);
  modport sink   (input valid, input drive, input integ_active, output ready);
endinterface

`default_nettype wire

[rtl/pidsa_regs.sv]
// APB-style configuration register file of the PID separation anti-windup unit.
`default_nettype none

module pidsa_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pidsa_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output pidsa_pkg::pidsa_cfg_t        cfg
);
  import pidsa_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

  // Register writes complete in the access phase of a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PROP_GAIN:      cfg.prop_gain            <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN:     cfg.integ_gain           <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN_EFF: cfg.deriv_gain_eff       <= pwdata[GAIN_W-1:0];
        REG_SEP_THRESHOLD:  cfg.separation_threshold <= pwdata[GAIN_W-1:0];
        REG_WINDUP_HIGH:    cfg.windup_high          <= pwdata;
        REG_WINDUP_LOW:     cfg.windup_low           <= pwdata;
        REG_OUT_HIGH:       cfg.out_high             <= pwdata;
        REG_OUT_LOW:        cfg.out_low              <= pwdata;
        default:            cfg                      <= cfg;
      endcase
    end
  end

  // Read back the addressed register.
  always_comb begin
    unique case (idx)
      REG_PROP_GAIN:      prdata = {1'b0, cfg.prop_gain};
      REG_INTEG_GAIN:     prdata = {1'b0, cfg.integ_gain};
      REG_DERIV_GAIN_EFF: prdata = {1'b0, cfg.deriv_gain_eff};
      REG_SEP_THRESHOLD:  prdata = {1'b0, cfg.separation_threshold};
      REG_WINDUP_HIGH:    prdata = cfg.windup_high;
      REG_WINDUP_LOW:     prdata = cfg.windup_low;
      REG_OUT_HIGH:       prdata = cfg.out_high;
      REG_OUT_LOW:        prdata = cfg.out_low;
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/pidsa_core.sv]
// Pipelined PID data path: error, integral and derivative state, products and clamp.
`default_nettype none

module pidsa_core (
  input  logic                                clk,
  input  logic                                rst,
  input  pidsa_pkg::pidsa_cfg_t               cfg,
  input  pidsa_pkg::pidsa_adv_t               adv,
  input  logic                                action,
  input  logic signed [pidsa_pkg::DATA_W-1:0] setpoint,
  input  logic signed [pidsa_pkg::DATA_W-1:0] measured,
  output logic signed [pidsa_pkg::DATA_W-1:0] drive,
  output logic                                integ_active
);
  import pidsa_pkg::*;

  localparam logic signed [DATA_W-1:0] D_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] D_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [INTEG_W-1:0] I_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] I_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  // Loop state carried from item to item.
  logic signed [DATA_W-1:0]  prior_error;
  logic signed [INTEG_W-1:0] integ_sum;
  logic signed [DATA_W-1:0]  deriv_prior;

  // Stage 1: input register.
  logic                      s1_clr;
  logic signed [DATA_W-1:0]  s1_setpoint;
  logic signed [DATA_W-1:0]  s1_measured;

  always_ff @(posedge clk) begin
    if (adv.ld1) begin
      s1_clr      <= (action == ACT_CLEAR);
      s1_setpoint <= setpoint;
      s1_measured <= measured;
    end
  end

  // Error, difference, separation test and integral update.
  logic signed [DATA_W:0]    err_wide;
  logic signed [DATA_W-1:0]  err;
  logic signed [DATA_W:0]    diff_wide;
  logic signed [DATA_W-1:0]  diff;
  logic        [DATA_W-1:0]  mag;
  logic                      active;
  logic signed [DATA_W:0]    pair;
  logic signed [DATA_W-1:0]  half;
  logic                      above;
  logic                      below;
  logic                      err_le0;
  logic                      err_ge0;
  logic                      apply;
  logic signed [INTEG_W:0]   integ_wide;
  logic signed [INTEG_W-1:0] integ_sat;
  logic signed [INTEG_W-1:0] integ_sum_next;

  always_comb begin
    err_wide = {s1_setpoint[DATA_W-1], s1_setpoint} - {s1_measured[DATA_W-1], s1_measured};
    if (err_wide[DATA_W] != err_wide[DATA_W-1]) begin
      err = err_wide[DATA_W] ? D_MIN : D_MAX;
    end else begin
      err = err_wide[DATA_W-1:0];
    end

    diff_wide = {err[DATA_W-1], err} - {prior_error[DATA_W-1], prior_error};
    if (diff_wide[DATA_W] != diff_wide[DATA_W-1]) begin
      diff = diff_wide[DATA_W] ? D_MIN : D_MAX;
    end else begin
      diff = diff_wide[DATA_W-1:0];
    end

    // A true magnitude: the most negative error still fits unsigned.
    mag    = err[DATA_W-1] ? (~err + 1'b1) : err;
    active = (mag <= {1'b0, cfg.separation_threshold});

    // Trapezoid half-sum, rounded towards minus infinity.
    pair = {err[DATA_W-1], err} + {prior_error[DATA_W-1], prior_error};
    half = pair[DATA_W:1];

    // Anti-windup: past a window limit only a step back towards it is taken.
    above   = integ_sum >
              $signed({{(INTEG_W-DATA_W){cfg.windup_high[DATA_W-1]}}, cfg.windup_high});
    below   = integ_sum <
              $signed({{(INTEG_W-DATA_W){cfg.windup_low[DATA_W-1]}}, cfg.windup_low});
    err_le0 = err[DATA_W-1] || (err == '0);
    err_ge0 = !err[DATA_W-1];
    if (above) begin
      apply = err_le0;
    end else if (below) begin
      apply = err_ge0;
    end else begin
      apply = 1'b1;
    end

    integ_wide = {integ_sum[INTEG_W-1], integ_sum}
               + {{(INTEG_W+1-DATA_W){half[DATA_W-1]}}, half};
    if (integ_wide[INTEG_W] != integ_wide[INTEG_W-1]) begin
      integ_sat = integ_wide[INTEG_W] ? I_MIN : I_MAX;
    end else begin
      integ_sat = integ_wide[INTEG_W-1:0];
    end
    integ_sum_next = (active && apply) ? integ_sat : integ_sum;
  end

  // Error and integral state advance as an item enters stage 2.
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_error <= '0;
      integ_sum   <= '0;
    end else if (adv.ld2) begin
      if (s1_clr) begin
        prior_error <= '0;
        integ_sum   <= '0;
      end else begin
        prior_error <= err;
        integ_sum   <= integ_sum_next;
      end
    end
  end

  // Stage 2 register.
  logic                      s2_clr;
  logic                      s2_active;
  logic signed [DATA_W-1:0]  s2_err;
  logic signed [DATA_W-1:0]  s2_diff;
  logic signed [INTEG_W-1:0] s2_integ;

  always_ff @(posedge clk) begin
    if (adv.ld2) begin
      s2_clr    <= s1_clr;
      s2_active <= active;
      s2_err    <= err;
      s2_diff   <= diff;
      s2_integ  <= integ_sum_next;
    end
  end

  // Gain products; the integral product is split at the binary point.
  logic signed [PROD_W:0]      p_prod;
  logic signed [PROD_W:0]      d_prod;
  logic signed [IHIPROD_W:0]   ihi_prod;
  logic        [GAIN_W+FRAC_W-1:0] ilo_prod;

  always_comb begin
    p_prod   = $signed({1'b0, cfg.prop_gain}) * s2_err;
    d_prod   = $signed({1'b0, cfg.deriv_gain_eff}) * s2_diff;
    ihi_prod = $signed({1'b0, cfg.integ_gain}) * $signed(s2_integ[INTEG_W-1:FRAC_W]);
    ilo_prod = cfg.integ_gain * s2_integ[FRAC_W-1:0];
  end

  // Stage 3 register.
  logic                       s3_clr;
  logic                       s3_active;
  logic signed [PTERM_W-1:0]  s3_p;
  logic signed [PTERM_W-1:0]  s3_d;
  logic signed [IHIPROD_W-1:0] s3_ihi;
  logic        [ILO_W-1:0]    s3_ilo;

  always_ff @(posedge clk) begin
    if (adv.ld3) begin
      s3_clr    <= s2_clr;
      s3_active <= s2_active;
      s3_p      <= p_prod[PROD_W-1:FRAC_W];
      s3_d      <= d_prod[PROD_W-1:FRAC_W];
      s3_ihi    <= ihi_prod[IHIPROD_W-1:0];
      s3_ilo    <= ilo_prod[GAIN_W+FRAC_W-1:FRAC_W];
    end
  end

  // Filtered derivative and integral term.
  logic signed [APROD_W:0]     a_prod;
  logic signed [DATA_W-1:0]    a_term;
  logic signed [DSUM_W-1:0]    d_sum;
  logic signed [DATA_W-1:0]    dout;
  logic signed [ITERM_W-1:0]   i_term;

  always_comb begin
    a_prod = $signed({1'b0, FILTER_ALPHA}) * deriv_prior;
    a_term = a_prod[APROD_W-1:FRAC_W];
    d_sum  = {s3_d[PTERM_W-1], s3_d} + {{(DSUM_W-DATA_W){a_term[DATA_W-1]}}, a_term};
    if ((d_sum[DSUM_W-1:DATA_W-1] == '0) || (d_sum[DSUM_W-1:DATA_W-1] == '1)) begin
      dout = d_sum[DATA_W-1:0];
    end else begin
      dout = d_sum[DSUM_W-1] ? D_MIN : D_MAX;
    end
    i_term = {s3_ihi[IHIPROD_W-1], s3_ihi} + {{(ITERM_W-ILO_W){1'b0}}, s3_ilo};
  end

  // Derivative state advances as an item enters stage 4.
  always_ff @(posedge clk) begin
    if (rst) begin
      deriv_prior <= '0;
    end else if (adv.ld4) begin
      deriv_prior <= s3_clr ? '0 : dout;
    end
  end

  // Stage 4 register.
  logic                      s4_clr;
  logic                      s4_active;
  logic signed [PTERM_W-1:0] s4_p;
  logic signed [DATA_W-1:0]  s4_d;
  logic signed [ITERM_W-1:0] s4_i;

  always_ff @(posedge clk) begin
    if (adv.ld4) begin
      s4_clr    <= s3_clr;
      s4_active <= s3_active;
      s4_p      <= s3_p;
      s4_d      <= dout;
      s4_i      <= s3_active ? i_term : '0;
    end
  end

  // Output sum and clamp; the upper limit is tested first, so it wins where a sum exceeds both.
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  lim_hi;
  logic signed [SUM_W-1:0]  lim_lo;
  logic signed [DATA_W-1:0] drive_next;
  logic                     integ_active_next;

  always_comb begin
    sum = {{(SUM_W-PTERM_W){s4_p[PTERM_W-1]}}, s4_p}
        + {{(SUM_W-DATA_W){s4_d[DATA_W-1]}}, s4_d}
        + {{(SUM_W-ITERM_W){s4_i[ITERM_W-1]}}, s4_i};
    lim_hi = {{(SUM_W-DATA_W){cfg.out_high[DATA_W-1]}}, cfg.out_high};
    lim_lo = {{(SUM_W-DATA_W){cfg.out_low[DATA_W-1]}}, cfg.out_low};
    if (s4_clr) begin
      drive_next = '0;
    end else if (sum > lim_hi) begin
      drive_next = cfg.out_high;
    end else if (sum < lim_lo) begin
      drive_next = cfg.out_low;
    end else begin
      drive_next = sum[DATA_W-1:0];
    end
    integ_active_next = !s4_clr && s4_active;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (adv.ld_out) begin
      drive        <= drive_next;
      integ_active <= integ_active_next;
    end
  end

endmodule

`default_nettype wire

[rtl/pid_separation_antiwindup_unit.sv]
// Top level of the PID separation anti-windup unit: flow control, registers and data path.
`default_nettype none
`include "pid_separation_antiwindup_unit_defines.svh"

// Positional PID controller in signed Q16.16 with integral separation and
// anti-windup. Each sample transfer carries an action, a setpoint and a
// measurement; a regulate sample yields one clamped drive value and a flag that
// tells whether the integral term took part, and a clear sample zeroes the loop
// state and yields a drive of zero. The unit accepts one sample per clock cycle
// when not stalled, returns results in order. The data path is a five-register
// pipeline (input, error and integral update, gain products, filtered
// derivative, output clamp); the integral recurrence closes within the second
// stage and the filtered derivative within the fourth, which is what allows a
// new sample each cycle absent a stall. Each pipeline register only waits for
// the one after it, so a result held at the output does not stop samples from
// filling empty stages. Gains, separation threshold, window and output limits
// must be written via the APB port while the unit is idle; it is not enforced.
module pid_separation_antiwindup_unit (
  input  logic                         clk,
  input  logic                         rst,
  pidsa_in_if.sink                     sample,
  pidsa_out_if.source                  result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pidsa_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import pidsa_pkg::*;

  pidsa_cfg_t cfg;
  pidsa_adv_t adv;

  assign pready = 1'b1;

  pidsa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Stage occupancy and the result valid flag.
  logic v1, v2, v3, v4, ov;
  logic mv1, mv2, mv3, mv4;
  logic can1, can2, can3, can4, can_out;
  logic in_acc;

  // Each stage moves on when the next one is empty or moving itself.
  always_comb begin
    can_out = !ov || result.ready;
    mv4     = v4 && can_out;
    can4    = !v4 || mv4;
    mv3     = v3 && can4;
    can3    = !v3 || mv3;
    mv2     = v2 && can3;
    can2    = !v2 || mv2;
    mv1     = v1 && can2;
    can1    = !v1 || mv1;
    in_acc  = sample.valid && can1;

    adv.ld1    = in_acc;
    adv.ld2    = mv1;
    adv.ld3    = mv2;
    adv.ld4    = mv3;
    adv.ld_out = mv4;
  end

  assign sample.ready = can1;
  assign result.valid = ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      ov <= 1'b0;
    end else begin
      v1 <= in_acc || (v1 && !mv1);
      v2 <= mv1 || (v2 && !mv2);
      v3 <= mv2 || (v3 && !mv3);
      v4 <= mv3 || (v4 && !mv4);
      ov <= mv4 || (ov && !result.ready);
    end
  end

  pidsa_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .adv          (adv),
    .action       (sample.action),
    .setpoint     (sample.setpoint),
    .measured     (sample.measured),
    .drive        (result.drive),
    .integ_active (result.integ_active)
  );

  // With the consumer ready, every stage drains and the input is always ready.
  `PIDSA_ASSERT_IMP(a_ready_when_drained, result.ready, sample.ready, "input stalled with output ready")
  // A finished item in the last stage reaches the output when the consumer is ready.
  `PIDSA_ASSERT_NXT(a_last_stage_drains, v4 && result.ready, result.valid, "last stage failed to drain")
  // Under back-pressure the last stage and the output both keep their items.
  `PIDSA_ASSERT_NXT(a_hold_on_stall, v4 && ov && !result.ready, v4 && ov, "item lost under stall")

endmodule

`default_nettype wire
